// ----- src/decimal_text_to_fixed_point_macros.svh -----
// ----------------------------------------------------------------------------
// Decimal text to fixed point: assertion macros
// Concurrent check forms used by the top-level file's assertions.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTTFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTTFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/dttfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal text to fixed point: package
// Payload types, status codes, character codes and the power-of-ten table.
// ----------------------------------------------------------------------------
`default_nettype none

package dttfp_pkg;

    localparam int unsigned IntWidth  = 31;
    localparam int unsigned FracWidth = 30;
    localparam int unsigned CntWidth  = 4;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR     = 2'd1;
    localparam logic [1:0] ST_SECOND_POINT = 2'd2;
    localparam logic [1:0] ST_OVERFLOW     = 2'd3;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [34:0] INT_LIMIT = 35'h0_7FFF_FFFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic prep;
        logic step;
        logic load;
    } t_cmd;

    function automatic logic [FracWidth-1:0] pow10(input logic [CntWidth-1:0] n);
        logic [FracWidth-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- src/dttfp_dpath.sv -----
// ----------------------------------------------------------------------------
// Decimal text to fixed point: datapath
// Character accumulators, bit-serial fraction divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dttfp_dpath #(
    parameter int unsigned MAX_FRACTION_DIGITS = 9,
    parameter int unsigned FRACTION_BITS       = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  dttfp_pkg::t_cmd       i_cmd,
    input  dttfp_pkg::t_in_item   i_in_data,
    output dttfp_pkg::t_out_item  o_out_data
);
    import dttfp_pkg::*;

    logic [IntWidth-1:0]      r_int_acc, n_int_acc;
    logic [FracWidth-1:0]     r_frac_acc, n_frac_acc;
    logic [CntWidth-1:0]      r_frac_cnt, n_frac_cnt;
    logic                     r_point, n_point;
    logic                     r_neg, n_neg;
    logic                     r_first, n_first;
    logic [1:0]               r_err, n_err;
    logic [FracWidth:0]       r_rem;
    logic [FracWidth-1:0]     r_div;
    logic [FRACTION_BITS-1:0] r_quot;
    t_out_item                r_out;

    logic [7:0]          w_char;
    logic [3:0]          w_digit;
    logic                w_is_digit;
    logic [34:0]         w_int_next;
    logic [FracWidth:0]  w_rem2;
    logic                w_fits;
    logic [63:0]         w_mag;
    logic [63:0]         w_value;

    assign w_char     = i_in_data.char_code;
    assign w_is_digit = (w_char >= CH_ZERO) && (w_char <= CH_NINE);
    assign w_digit    = 4'(w_char - CH_ZERO);
    assign w_int_next = {1'b0, r_int_acc, 3'b000} + {3'b000, r_int_acc, 1'b0}
                      + {31'd0, w_digit};

    always_comb begin
        n_int_acc  = r_int_acc;
        n_frac_acc = r_frac_acc;
        n_frac_cnt = r_frac_cnt;
        n_point    = r_point;
        n_neg      = r_neg;
        n_first    = r_first;
        n_err      = r_err;
        if (i_cmd.load) begin
            n_int_acc  = '0;
            n_frac_acc = '0;
            n_frac_cnt = '0;
            n_point    = 1'b0;
            n_neg      = 1'b0;
            n_first    = 1'b1;
            n_err      = ST_OK;
        end else if (i_cmd.take) begin
            n_first = 1'b0;
            if (w_char == CH_MINUS) begin
                if (r_first) begin
                    n_neg = 1'b1;
                end else if (r_err == ST_OK) begin
                    n_err = ST_BAD_CHAR;
                end
            end else if (w_char == CH_POINT) begin
                if (r_point && (r_err == ST_OK)) begin
                    n_err = ST_SECOND_POINT;
                end
                n_point = 1'b1;
            end else if (!w_is_digit) begin
                if (r_err == ST_OK) begin
                    n_err = ST_BAD_CHAR;
                end
            end else if (r_point) begin
                if (r_frac_cnt < CntWidth'(MAX_FRACTION_DIGITS)) begin
                    n_frac_acc = FracWidth'({r_frac_acc, 3'b000} + {2'b00, r_frac_acc, 1'b0}
                                            + {29'd0, w_digit});
                    n_frac_cnt = r_frac_cnt + CntWidth'(1);
                end
            end else if (w_int_next > INT_LIMIT) begin
                n_int_acc = INT_LIMIT[IntWidth-1:0];
                if (r_err == ST_OK) begin
                    n_err = ST_OVERFLOW;
                end
            end else begin
                n_int_acc = w_int_next[IntWidth-1:0];
            end
        end
    end

    assign w_rem2 = {r_rem[FracWidth-1:0], 1'b0};
    assign w_fits = w_rem2 >= {1'b0, r_div};

    assign w_mag   = (64'(r_int_acc) << FRACTION_BITS) | 64'(r_quot);
    assign w_value = ((r_err == ST_BAD_CHAR) || (r_err == ST_SECOND_POINT)) ? 64'd0 :
                     (r_neg ? (64'd0 - w_mag) : w_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_acc  <= '0;
            r_frac_acc <= '0;
            r_frac_cnt <= '0;
            r_point    <= 1'b0;
            r_neg      <= 1'b0;
            r_first    <= 1'b1;
            r_err      <= ST_OK;
        end else begin
            r_int_acc  <= n_int_acc;
            r_frac_acc <= n_frac_acc;
            r_frac_cnt <= n_frac_cnt;
            r_point    <= n_point;
            r_neg      <= n_neg;
            r_first    <= n_first;
            r_err      <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rem  <= {1'b0, r_frac_acc};
            r_div  <= pow10(r_frac_cnt);
            r_quot <= '0;
        end else if (i_cmd.step) begin
            r_rem  <= w_fits ? (w_rem2 - {1'b0, r_div}) : w_rem2;
            r_quot <= {r_quot[FRACTION_BITS-2:0], w_fits};
        end
        if (i_cmd.load) begin
            r_out.value  <= w_value;
            r_out.status <= r_err;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

// ----- src/dttfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Decimal text to fixed point: controller
// Sequences character intake, divider setup, divider steps and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module dttfp_ctrl #(
    parameter int unsigned FRACTION_BITS = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_last,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output dttfp_pkg::t_cmd      o_cmd
);
    import dttfp_pkg::*;

    localparam int unsigned CW = $clog2(FRACTION_BITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_LOAD
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd.take = i_in_valid && o_in_ready;
        o_cmd.prep = (r_state == S_PREP);
        o_cmd.step = (r_state == S_DIV);
        o_cmd.load = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.take && i_in_last) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(FRACTION_BITS - 1)) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (o_cmd.load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- src/decimal_text_to_fixed_point.sv -----
// ----------------------------------------------------------------------------
// Decimal text to fixed point
// Parses one decimal character per transfer into signed fixed point.
//
//   Channel   Signals                              Direction
//   input     i_in_valid, o_in_ready, i_in_data    char_code, is_last in
//   output    o_out_valid, i_out_ready, o_out_data value, status out
//
// Characters are taken while the parser is idle. A final character adds a setup
// step, FRACTION_BITS steps of the one-bit-per-cycle fraction divider and a
// load step; no character is taken until that result is loaded.
// Reset is synchronous and returns the parser to the start of a string.
// Characters of the next string are taken while a result waits on the output;
// a stalled output holds only the load of the following result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_text_to_fixed_point_macros.svh"

module decimal_text_to_fixed_point #(
    parameter int unsigned MAX_FRACTION_DIGITS = 9,
    parameter int unsigned FRACTION_BITS       = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  dttfp_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output dttfp_pkg::t_out_item  o_out_data
);
    import dttfp_pkg::*;

    t_cmd w_cmd;

    dttfp_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.is_last),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    dttfp_dpath #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
        .FRACTION_BITS       (FRACTION_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

    `DTTFP_ASSERT_SAME(a_no_take_while_dividing, w_cmd.step || w_cmd.prep, !o_in_ready, "input taken during division")
    `DTTFP_ASSERT_NEXT(a_last_starts_division, i_in_valid && o_in_ready && i_in_data.is_last, w_cmd.prep, "last character did not start division")
    `DTTFP_ASSERT_NEXT(a_load_shows_result, w_cmd.load, o_out_valid, "loaded result not presented")
    `DTTFP_ASSERT_SAME(a_error_value_zero, o_out_valid && ((o_out_data.status == ST_BAD_CHAR) || (o_out_data.status == ST_SECOND_POINT)), o_out_data.value == 64'sd0, "error result carries a nonzero value")

endmodule

`default_nettype wire

// ----- dv/decimal_text_to_fixed_point_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: transfer checker
// Watches both channels, parses every accepted character with its own copy of
// the parser state, queues the fixed-point number and status that each final
// character should produce, and compares every output transfer against the
// oldest queued number field by field.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_checker #(
    parameter int unsigned MAX_FRACTION_DIGITS = 9,
    parameter int unsigned FRACTION_BITS       = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_in_ready,
    input  dttfp_pkg::t_in_item   i_in_data,
    input  wire                   i_out_valid,
    input  wire                   i_out_ready,
    input  dttfp_pkg::t_out_item  i_out_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    import dttfp_pkg::*;

    logic [30:0] int_digits;
    logic [29:0] frac_digits;
    logic [3:0]  frac_count;
    logic        point_taken;
    logic        minus_taken;
    logic        first_char;
    logic [1:0]  first_error;

    t_out_item   parsed_numbers[$];
    t_out_item   oldest_number;
    int          mismatches = 0;
    int          waiting    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function void restart_number();
        int_digits  = '0;
        frac_digits = '0;
        frac_count  = '0;
        point_taken = 1'b0;
        minus_taken = 1'b0;
        first_char  = 1'b1;
        first_error = ST_OK;
    endfunction

    function void flag_error(input logic [1:0] code);
        if (first_error == ST_OK) first_error = code;
    endfunction

    function void parse_char(input logic [7:0] c);
        logic        was_first;
        logic [31:0] digit;
        was_first  = first_char;
        first_char = 1'b0;
        digit      = {24'd0, c - CH_ZERO};
        if (c == CH_MINUS) begin
            if (was_first) minus_taken = 1'b1;
            else flag_error(ST_BAD_CHAR);
        end else if (c == CH_POINT) begin
            if (point_taken) flag_error(ST_SECOND_POINT);
            point_taken = 1'b1;
        end else if (c < CH_ZERO || c > CH_NINE) begin
            flag_error(ST_BAD_CHAR);
        end else if (point_taken) begin
            if (frac_count < MAX_FRACTION_DIGITS) begin
                frac_digits = frac_digits * 30'd10 + digit[29:0];
                frac_count  = frac_count + 4'd1;
            end
        end else if ({1'b0, int_digits} > (32'h7FFF_FFFF - digit) / 32'd10) begin
            int_digits = 31'h7FFF_FFFF;
            flag_error(ST_OVERFLOW);
        end else begin
            int_digits = int_digits * 31'd10 + digit[30:0];
        end
    endfunction

    function t_out_item fixed_point_number();
        t_out_item   num;
        logic [63:0] scale;
        logic [63:0] frac;
        logic [63:0] magnitude;
        scale = 64'd1;
        for (int i = 0; i < frac_count && i < 9; i++) scale = scale * 64'd10;
        frac      = ({34'd0, frac_digits} << FRACTION_BITS) / scale;
        magnitude = ({33'd0, int_digits} << FRACTION_BITS) + frac;
        num.status = first_error;
        if (first_error == ST_BAD_CHAR || first_error == ST_SECOND_POINT)
            num.value = '0;
        else
            num.value = minus_taken ? -magnitude : magnitude;
        return num;
    endfunction

    function void report_mismatch(input string what, input t_out_item want,
                                  input t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected value %0d status %0d, got value %0d status %0d",
                     $realtime, what, want.value, want.status, got.value, got.status);
    endfunction

    initial restart_number();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_number();
            parsed_numbers.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                parse_char(i_in_data.char_code);
                if (i_in_data.is_last) begin
                    parsed_numbers.push_back(fixed_point_number());
                    restart_number();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (parsed_numbers.size() == 0) begin
                    report_mismatch("output transfer with nothing pending", '0, i_out_data);
                end else begin
                    oldest_number = parsed_numbers.pop_front();
                    if (i_out_data.value !== oldest_number.value
                            || i_out_data.status !== oldest_number.status)
                        report_mismatch("wrong number", oldest_number, i_out_data);
                end
            end
        end
        waiting = parsed_numbers.size();
    end

endmodule

// ----- dv/decimal_text_to_fixed_point_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: testbench
// Sends directed and random number strings one character per transfer, with
// the sender idling and the receiver stalling in several phases, including a
// long receiver hold-off and a full drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_tb;
    import dttfp_pkg::*;

    localparam int unsigned MaxFracDigits = 9;
    localparam int unsigned FracBits      = 32;
    localparam int          ItemTotal     = 1700;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    int        fail_count;
    int        pending;
    int        idle_pct    = 0;
    int        stall_pct   = 0;
    int        hold_left   = 0;
    int        chars_sent  = 0;
    logic [7:0] number_text[$];

    decimal_text_to_fixed_point #(
        .MAX_FRACTION_DIGITS(MaxFracDigits),
        .FRACTION_BITS      (FracBits)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    decimal_text_to_fixed_point_checker #(
        .MAX_FRACTION_DIGITS(MaxFracDigits),
        .FRACTION_BITS      (FracBits)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("decimal_text_to_fixed_point_tb: done, errors");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{char_code: c, is_last: last};
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < number_text.size(); i++)
            send_char(number_text[i], i == number_text.size() - 1);
    endtask

    task automatic send_literal(input string s);
        number_text.delete();
        for (int i = 0; i < s.len(); i++) number_text.push_back(s[i]);
        send_text();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic start_hold(input int cycles);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        hold_left = cycles;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function void build_random_text();
        int    int_len;
        int    frac_len;
        int    noise_len;
        int    pick;
        string limit_head;
        limit_head = "214748364";
        number_text.delete();
        if ($urandom_range(99) < 75) begin
            if ($urandom_range(3) == 0) number_text.push_back(CH_MINUS);
            if ($urandom_range(19) == 0) begin
                for (int i = 0; i < limit_head.len(); i++) number_text.push_back(limit_head[i]);
                number_text.push_back(CH_ZERO + 8'($urandom_range(6, 9)));
            end else begin
                int_len = ($urandom_range(7) == 0) ? $urandom_range(9, 12)
                                                   : $urandom_range(0, 6);
                for (int i = 0; i < int_len; i++) number_text.push_back(random_digit());
            end
            if ($urandom_range(9) < 7) begin
                number_text.push_back(CH_POINT);
                frac_len = ($urandom_range(4) == 0) ? $urandom_range(8, 12)
                                                    : $urandom_range(0, 5);
                for (int i = 0; i < frac_len; i++) number_text.push_back(random_digit());
            end
            if (number_text.size() == 0) number_text.push_back(random_digit());
        end else begin
            noise_len = $urandom_range(1, 8);
            for (int i = 0; i < noise_len; i++) begin
                pick = $urandom_range(9);
                if (pick < 3)      number_text.push_back(8'($urandom_range(255)));
                else if (pick < 5) number_text.push_back(CH_MINUS);
                else if (pick < 7) number_text.push_back(CH_POINT);
                else               number_text.push_back(random_digit());
            end
        end
    endfunction

    initial begin
        int sender_idle[4];
        int receiver_stall[4];
        sender_idle    = '{0, 78, 0, 9};
        receiver_stall = '{0, 0, 78, 9};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_literal("-.5");
        send_literal("1-");
        send_literal("1..2");
        number_text.delete();
        number_text.push_back(8'hFF);
        number_text.push_back(8'h00);
        send_text();
        send_literal(".");
        send_literal("-");
        send_literal("9999999999");
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = sender_idle[phase];
            stall_pct = receiver_stall[phase];
            if (phase == 0) start_hold(400);
            while (chars_sent < ItemTotal * (phase + 1) / 4) begin
                build_random_text();
                send_text();
                if (phase == 1 && $urandom_range(49) == 0) drain();
            end
            drain();
        end

        repeat (FracBits + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("decimal_text_to_fixed_point_tb: done, clean");
        end else begin
            $display("decimal_text_to_fixed_point_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/dttfp_pkg.sv
src/dttfp_dpath.sv
src/dttfp_ctrl.sv
src/decimal_text_to_fixed_point.sv
dv/decimal_text_to_fixed_point_checker.sv
dv/decimal_text_to_fixed_point_tb.sv
